@@ rtl/grsm_pkg.sv @@
// Shared types and constants for the Golomb-Rice set membership scan.
`default_nettype none

package grsm_pkg;

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   localparam logic [1:0] CSR_RICE_BITS   = 2'd0;
   localparam logic [1:0] CSR_SET_COUNT   = 2'd1;
   localparam logic [1:0] CSR_FP_RATE     = 2'd2;
   localparam logic [1:0] CSR_TARGET_HASH = 2'd3;

   localparam logic [5:0]  RICE_BITS_RESET = 6'd19;
   localparam logic [31:0] SET_COUNT_RESET = 32'd0;
   localparam logic [31:0] FP_RATE_RESET   = 32'd784931;
   localparam logic [63:0] TARGET_RESET    = 64'd0;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       first_byte;
      logic       last_byte;
   } grsm_req_type;

   typedef struct packed {
      logic        matched;
      logic [31:0] elements_decoded;
      logic        ran_out;
   } grsm_rsp_type;

   typedef struct packed {
      logic [5:0]  rice_bits;
      logic [31:0] set_count;
      logic [31:0] fp_rate;
      logic [63:0] target_hash;
   } grsm_cfg_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RANGE,
      ST_BITS,
      ST_FIN
   } grsm_state_type;

endpackage

`default_nettype wire

@@ rtl/grsm_front.sv @@
// Input word queue between the request port and the bit-serial decoder.
`default_nettype none

module grsm_front
   import grsm_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push,
   output logic              full,
   input  wire grsm_req_type push_data,
   output logic              empty,
   input  wire logic         pop,
   output grsm_req_type      pop_data
);

   grsm_req_type            entries_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0]   count_ff, count_in;
   logic                    do_push, do_pop;

   assign full     = (count_ff == FIFO_CNT_W'(FIFO_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? FIFO_PTR_W'((wr_ptr_ff + 1'b1) % FIFO_DEPTH) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? FIFO_PTR_W'((rd_ptr_ff + 1'b1) % FIFO_DEPTH) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

@@ rtl/grsm_range.sv @@
// Target range mapping: high 64 bits of hash * (rate * size) on one 32x32 multiplier.
`default_nettype none

module grsm_range
   import grsm_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire grsm_cfg_type cfg,
   input  wire logic         start,
   output logic              done,
   output logic [63:0]       range_value
);

   logic [2:0]  step_ff, step_in;
   logic [63:0] mul_ff, mul_in;
   logic [63:0] b_ff, b_in;
   logic [95:0] acc_ff, acc_in;
   logic [31:0] mul_a, mul_b;

   assign done        = (step_ff == 3'd6);
   assign range_value = acc_ff[95:32];

   // operand selection for the partial products
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (step_ff)
         3'd0: begin
            mul_a = cfg.fp_rate;
            mul_b = cfg.set_count;
         end
         3'd1: begin
            mul_a = cfg.target_hash[31:0];
            mul_b = mul_ff[31:0];
         end
         3'd2: begin
            mul_a = cfg.target_hash[31:0];
            mul_b = b_ff[63:32];
         end
         3'd3: begin
            mul_a = cfg.target_hash[63:32];
            mul_b = b_ff[31:0];
         end
         3'd4: begin
            mul_a = cfg.target_hash[63:32];
            mul_b = b_ff[63:32];
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      mul_in  = {32'd0, mul_a} * {32'd0, mul_b};
      b_in    = b_ff;
      acc_in  = acc_ff;
      step_in = step_ff;
      case (step_ff)
         3'd0: if (start) step_in = 3'd1;
         3'd1: begin
            b_in    = mul_ff;
            step_in = 3'd2;
         end
         3'd2: begin
            acc_in  = {64'd0, mul_ff[63:32]};
            step_in = 3'd3;
         end
         3'd3, 3'd4: begin
            acc_in  = acc_ff + {32'd0, mul_ff};
            step_in = step_ff + 3'd1;
         end
         3'd5: begin
            acc_in  = acc_ff + {mul_ff, 32'd0};
            step_in = 3'd6;
         end
         default: step_in = 3'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
      end else begin
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      mul_ff <= mul_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
   end

endmodule

`default_nettype wire

@@ rtl/grsm_back.sv @@
// Bit-serial Golomb-Rice decoder, compare against target and result register.
`default_nettype none

module grsm_back
   import grsm_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire grsm_cfg_type cfg,
   input  wire logic         q_empty,
   input  wire grsm_req_type q_data,
   output logic              q_pop,
   output logic              range_start,
   input  wire logic         range_done,
   input  wire logic [63:0]  range_value,
   output logic              rsp_empty,
   input  wire logic         rsp_pop,
   output grsm_rsp_type      rsp_data
);

   grsm_state_type state_ff, state_in;
   logic [7:0]     byte_ff, byte_in;
   logic           last_ff, last_in;
   logic [2:0]     idx_ff, idx_in;
   logic           end_ff, end_in;
   logic [63:0]    quot_ff, quot_in;
   logic [63:0]    rem_ff, rem_in;
   logic [5:0]     left_ff, left_in;
   logic           in_rem_ff, in_rem_in;
   logic [63:0]    sum_ff, sum_in;
   logic [31:0]    count_ff, count_in;
   logic           done_ff, done_in;
   logic [63:0]    target_ff, target_in;
   logic           out_valid_ff, out_valid_in;
   grsm_rsp_type   out_ff, out_in;

   logic           fetch;
   logic           bit_val;
   logic           elem_end_bit;
   logic [63:0]    delta;
   logic [63:0]    value;
   logic [31:0]    count_inc;
   logic           fin_eq, fin_gt, fin_cnt, fin_decide;
   logic           emit;
   grsm_rsp_type   emit_data;

   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;

   // shared decode terms
   always_comb begin
      fetch        = (state_ff == ST_IDLE) && !q_empty && !out_valid_ff;
      bit_val      = byte_ff[idx_ff];
      elem_end_bit = (!in_rem_ff && !bit_val && (cfg.rice_bits == '0))
                   || (in_rem_ff && (left_ff == 6'd1));
      // remainder never reaches the shifted quotient bits, so OR is the add
      delta        = (quot_ff << cfg.rice_bits) | rem_ff;
      value        = sum_ff + delta;
      count_inc    = count_ff + 32'd1;
      fin_eq       = (value == target_ff);
      fin_gt       = (value > target_ff);
      fin_cnt      = (count_inc == cfg.set_count);
      fin_decide   = fin_eq || fin_gt || fin_cnt;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (fetch) begin
               if (q_data.first_byte) begin
                  state_in = ST_RANGE;
               end else if (!done_ff) begin
                  state_in = ST_BITS;
               end
            end
         end
         ST_RANGE: begin
            if (range_done) begin
               state_in = (cfg.set_count == '0) ? ST_IDLE : ST_BITS;
            end
         end
         ST_BITS: begin
            if (elem_end_bit) begin
               state_in = ST_FIN;
            end else if (idx_ff == '0) begin
               state_in = ST_IDLE;
            end
         end
         ST_FIN: begin
            state_in = (fin_decide || end_ff) ? ST_IDLE : ST_BITS;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      q_pop       = fetch;
      range_start = 1'b0;
      byte_in     = byte_ff;
      last_in     = last_ff;
      idx_in      = idx_ff;
      end_in      = end_ff;
      quot_in     = quot_ff;
      rem_in      = rem_ff;
      left_in     = left_ff;
      in_rem_in   = in_rem_ff;
      sum_in      = sum_ff;
      count_in    = count_ff;
      done_in     = done_ff;
      target_in   = target_ff;
      emit        = 1'b0;
      emit_data   = '{matched: 1'b0, elements_decoded: count_ff, ran_out: 1'b0};

      case (state_ff)
         ST_IDLE: begin
            if (fetch) begin
               byte_in = q_data.data_byte;
               last_in = q_data.last_byte;
               idx_in  = 3'd7;
               if (q_data.first_byte) begin
                  range_start = 1'b1;
                  quot_in     = '0;
                  rem_in      = '0;
                  left_in     = '0;
                  in_rem_in   = 1'b0;
                  sum_in      = '0;
                  count_in    = '0;
                  done_in     = 1'b0;
               end
            end
         end
         ST_RANGE: begin
            if (range_done) begin
               target_in = range_value;
               if (cfg.set_count == '0) begin
                  emit = 1'b1;
               end
            end
         end
         ST_BITS: begin
            if (!in_rem_ff) begin
               if (bit_val) begin
                  quot_in = quot_ff + 64'd1;
               end else if (cfg.rice_bits != '0) begin
                  in_rem_in = 1'b1;
                  left_in   = cfg.rice_bits;
                  rem_in    = '0;
               end
            end else begin
               rem_in  = {rem_ff[62:0], bit_val};
               left_in = left_ff - 6'd1;
            end
            if (elem_end_bit) begin
               end_in = (idx_ff == '0);
            end else if (idx_ff == '0) begin
               if (last_ff) begin
                  emit              = 1'b1;
                  emit_data.ran_out = 1'b1;
               end
            end else begin
               idx_in = idx_ff - 3'd1;
            end
         end
         ST_FIN: begin
            count_in  = count_inc;
            quot_in   = '0;
            rem_in    = '0;
            left_in   = '0;
            in_rem_in = 1'b0;
            emit_data.elements_decoded = count_inc;
            if (fin_eq) begin
               emit              = 1'b1;
               emit_data.matched = 1'b1;
            end else if (fin_gt) begin
               emit = 1'b1;
            end else begin
               sum_in = value;
               if (fin_cnt) begin
                  emit = 1'b1;
               end else if (end_ff) begin
                  if (last_ff) begin
                     emit              = 1'b1;
                     emit_data.ran_out = 1'b1;
                  end
               end else begin
                  idx_in = idx_ff - 3'd1;
               end
            end
         end
         default: begin
            emit = 1'b0;
         end
      endcase

      if (emit) begin
         done_in = 1'b1;
      end
      // a result is only produced when the register is free
      out_in       = emit ? emit_data : out_ff;
      out_valid_in = emit || (out_valid_ff && !rsp_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         done_ff      <= 1'b1;
         in_rem_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
         quot_ff      <= '0;
         rem_ff       <= '0;
         left_ff      <= '0;
         sum_ff       <= '0;
         count_ff     <= '0;
         target_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         done_ff      <= done_in;
         in_rem_ff    <= in_rem_in;
         out_valid_ff <= out_valid_in;
         quot_ff      <= quot_in;
         rem_ff       <= rem_in;
         left_ff      <= left_in;
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         target_ff    <= target_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      last_ff <= last_in;
      idx_ff  <= idx_in;
      end_ff  <= end_in;
      out_ff  <= out_in;
   end

endmodule

`default_nettype wire

@@ rtl/golomb_rice_set_membership_scan.sv @@
// Golomb-Rice coded set scan: top level with config registers, word queue and decoder.
// Each byte is fetched and then decoded bit by bit, with an extra compare state per element
//   completed in that byte for the sum add and compare; a first byte also waits for
//   target range mapping on the shared 32x32 multiplier. No new byte is fetched until
//   the current one is decoded and the result register is empty.
// Reset: synchronous, active high; clears queues and sets config registers to defaults.
`default_nettype none

module golomb_rice_set_membership_scan
   import grsm_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_push,
   output logic              req_full,
   input  wire grsm_req_type req_data,
   output logic              rsp_empty,
   input  wire logic         rsp_pop,
   output grsm_rsp_type      rsp_data,
   input  wire logic         csr_we,
   input  wire logic [1:0]   csr_index,
   input  wire logic [63:0]  csr_wdata
);

   grsm_cfg_type cfg_ff, cfg_in;
   logic         q_empty;
   logic         q_pop;
   grsm_req_type q_data;
   logic         range_start;
   logic         range_done;
   logic [63:0]  range_value;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_RICE_BITS:   cfg_in.rice_bits   = csr_wdata[5:0];
            CSR_SET_COUNT:   cfg_in.set_count   = csr_wdata[31:0];
            CSR_FP_RATE:     cfg_in.fp_rate     = csr_wdata[31:0];
            CSR_TARGET_HASH: cfg_in.target_hash = csr_wdata;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{rice_bits: RICE_BITS_RESET, set_count: SET_COUNT_RESET,
                     fp_rate: FP_RATE_RESET, target_hash: TARGET_RESET};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   grsm_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .full      (req_full),
      .push_data (req_data),
      .empty     (q_empty),
      .pop       (q_pop),
      .pop_data  (q_data)
   );

   grsm_range u_range (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .start       (range_start),
      .done        (range_done),
      .range_value (range_value)
   );

   grsm_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .q_empty     (q_empty),
      .q_data      (q_data),
      .q_pop       (q_pop),
      .range_start (range_start),
      .range_done  (range_done),
      .range_value (range_value),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_data    (rsp_data)
   );

endmodule

`default_nettype wire

@@ tb/scan_verdict_checker.sv @@
// Verdict checker for the set scan: watches all ports, predicts each verdict word, compares it.
module scan_verdict_checker
   import grsm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_push,
   input  logic         req_full,
   input  grsm_req_type req_data,
   input  logic         rsp_empty,
   input  logic         rsp_pop,
   input  grsm_rsp_type rsp_data,
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [63:0]  csr_wdata,
   output int           fail_count,
   output int           pending_count
);

   grsm_cfg_type regs;

   // decoder state, mirrored
   logic [63:0] target_range;
   logic [63:0] run_sum;
   logic [63:0] quot_cnt;
   logic [63:0] rem_acc;
   logic [5:0]  rem_left;
   logic [31:0] elem_cnt;
   logic        in_rem;
   logic        scan_done;

   grsm_rsp_type expected_verdicts[$];

   function automatic void clear_scan();
      run_sum   = '0;
      quot_cnt  = '0;
      rem_acc   = '0;
      rem_left  = '0;
      in_rem    = 1'b0;
      elem_cnt  = '0;
   endfunction

   function automatic void post_verdict(input logic hit, input logic starved);
      grsm_rsp_type v;
      v.matched          = hit;
      v.elements_decoded = elem_cnt;
      v.ran_out          = starved;
      expected_verdicts.push_back(v);
      scan_done = 1'b1;
   endfunction

   // Returns 1 when the completed element decides the scan.
   function automatic bit close_element();
      logic [63:0] delta;
      logic [63:0] total;
      delta    = (quot_cnt << regs.rice_bits) + rem_acc;
      total    = run_sum + delta;
      elem_cnt = elem_cnt + 32'd1;
      quot_cnt = '0;
      rem_acc  = '0;
      rem_left = '0;
      in_rem   = 1'b0;
      if (total == target_range) begin
         post_verdict(1'b1, 1'b0);
         return 1'b1;
      end
      if (total > target_range) begin
         post_verdict(1'b0, 1'b0);
         return 1'b1;
      end
      run_sum = total;
      if (elem_cnt == regs.set_count) begin
         post_verdict(1'b0, 1'b0);
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic void decode_byte(input grsm_req_type w);
      logic [63:0]  bound;
      logic [127:0] product;
      logic         b;
      if (w.first_byte) begin
         bound        = 64'(regs.fp_rate) * 64'(regs.set_count);
         product      = 128'(regs.target_hash) * 128'(bound);
         target_range = product[127:64];
         clear_scan();
         scan_done = 1'b0;
         // empty set decides before any bit is read
         if (regs.set_count == '0) begin
            post_verdict(1'b0, 1'b0);
            return;
         end
      end
      if (scan_done)
         return;
      for (int i = 7; i >= 0; i--) begin
         b = w.data_byte[i];
         if (!in_rem) begin
            if (b) begin
               quot_cnt = quot_cnt + 64'd1;
            end else if (regs.rice_bits == '0) begin
               if (close_element())
                  return;
            end else begin
               in_rem   = 1'b1;
               rem_left = regs.rice_bits;
               rem_acc  = '0;
            end
         end else begin
            rem_acc  = {rem_acc[62:0], b};
            rem_left = rem_left - 6'd1;
            if (rem_left == '0) begin
               if (close_element())
                  return;
            end
         end
      end
      if (w.last_byte)
         post_verdict(1'b0, 1'b1);
   endfunction

   always @(posedge clock) begin
      grsm_rsp_type want;
      if (reset) begin
         regs.rice_bits   = RICE_BITS_RESET;
         regs.set_count   = SET_COUNT_RESET;
         regs.fp_rate     = FP_RATE_RESET;
         regs.target_hash = TARGET_RESET;
         target_range     = '0;
         clear_scan();
         scan_done        = 1'b1;
         expected_verdicts.delete();
         fail_count       = 0;
         pending_count   <= 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_RICE_BITS:   regs.rice_bits   = csr_wdata[5:0];
               CSR_SET_COUNT:   regs.set_count   = csr_wdata[31:0];
               CSR_FP_RATE:     regs.fp_rate     = csr_wdata[31:0];
               CSR_TARGET_HASH: regs.target_hash = csr_wdata;
               default: ;
            endcase
         end
         if (req_push && !req_full)
            decode_byte(req_data);
         if (rsp_pop && !rsp_empty) begin
            if (expected_verdicts.size() == 0) begin
               $error("verdict word with none expected: matched %0d elements %0d ran_out %0d",
                      rsp_data.matched, rsp_data.elements_decoded, rsp_data.ran_out);
               fail_count++;
            end else begin
               want = expected_verdicts.pop_front();
               if (rsp_data.matched !== want.matched) begin
                  $error("matched: expected %0d, got %0d", want.matched, rsp_data.matched);
                  fail_count++;
               end
               if (rsp_data.elements_decoded !== want.elements_decoded) begin
                  $error("elements_decoded: expected %0d, got %0d",
                         want.elements_decoded, rsp_data.elements_decoded);
                  fail_count++;
               end
               if (rsp_data.ran_out !== want.ran_out) begin
                  $error("ran_out: expected %0d, got %0d", want.ran_out, rsp_data.ran_out);
                  fail_count++;
               end
            end
         end
         pending_count <= expected_verdicts.size();
      end
   end

endmodule

@@ tb/testbench.sv @@
// Top of the set scan testbench: clock, reset, encoded set streams, config writes, verdict.
module testbench;
   import grsm_pkg::*;

   localparam int TOTAL_WORDS = 1175;
   localparam int DRAIN_TAIL  = 250;
   localparam int HOLD_CYCLES = 400;
   localparam int CYCLE_LIMIT = 600000;
   localparam int QUOT_MAX    = 40;

   typedef enum {
      SCAN_MATCH,
      SCAN_PASS,
      SCAN_COUNT,
      SCAN_TRUNC,
      SCAN_NOISE
   } scan_kind_type;

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_push  = 1'b0;
   logic         req_full;
   grsm_req_type req_data  = '0;
   logic         rsp_empty;
   logic         rsp_pop   = 1'b0;
   grsm_rsp_type rsp_data;
   logic         csr_we    = 1'b0;
   logic [1:0]   csr_index = CSR_RICE_BITS;
   logic [63:0]  csr_wdata = '0;

   int fail_count;
   int pending_count;
   int cycle_count = 0;
   int words_sent  = 0;
   int burst_left  = 0;
   bit hold_request = 1'b0;

   // current phase setup, as chosen for stimulus shaping
   logic [5:0]  ph_rice;
   logic [31:0] ph_size;
   logic [63:0] ph_target;
   bit          stream_bits[$];

   golomb_rice_set_membership_scan i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   scan_verdict_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_data      (req_data),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_data      (rsp_data),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // receiver: stall pattern of its own, plus one long hold on request
   initial begin
      int mode_left;
      int pop_pct;
      mode_left = 0;
      pop_pct   = 100;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            rsp_pop <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode_left = $urandom_range(20, 200);
               case ($urandom_range(0, 3))
                  0:       pop_pct = 100;
                  1:       pop_pct = 70;
                  2:       pop_pct = 30;
                  default: pop_pct = 5;
               endcase
            end
            mode_left--;
            rsp_pop <= ($urandom_range(0, 99) < pop_pct);
         end
      end
   end

   function automatic logic [63:0] pick_upto(input logic [63:0] x);
      if (x == '1)
         return {$urandom, $urandom};
      return {$urandom, $urandom} % (x + 64'd1);
   endfunction

   task automatic send_word(input grsm_req_type w);
      int idle;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         idle = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (idle > 0) begin
            req_push <= 1'b0;
            repeat (idle) @(posedge clock);
         end
      end
      burst_left--;
      req_push <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (req_full);
      words_sent++;
   endtask

   // sender stops offering until every expected verdict is back
   task automatic wait_for_results(input int tail);
      req_push <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (tail) @(posedge clock);
   endtask

   task automatic write_regs(input logic [5:0] rice, input logic [31:0] size_n,
                             input logic [31:0] rate, input logic [63:0] hash);
      csr_we    <= 1'b1;
      csr_index <= CSR_RICE_BITS;
      csr_wdata <= 64'(rice);
      @(posedge clock);
      csr_index <= CSR_SET_COUNT;
      csr_wdata <= 64'(size_n);
      @(posedge clock);
      csr_index <= CSR_FP_RATE;
      csr_wdata <= 64'(rate);
      @(posedge clock);
      csr_index <= CSR_TARGET_HASH;
      csr_wdata <= hash;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   function automatic void put_element(input logic [63:0] d);
      logic [63:0] q;
      q = d >> ph_rice;
      if (q > 64'(QUOT_MAX))
         q = 64'($urandom_range(0, 3));
      repeat (int'(q)) stream_bits.push_back(1'b1);
      stream_bits.push_back(1'b0);
      for (int i = int'(ph_rice) - 1; i >= 0; i--)
         stream_bits.push_back(d[i]);
   endfunction

   task automatic send_stream(input bit with_last);
      grsm_req_type w;
      int nbytes;
      while (stream_bits.size() % 8 != 0)
         stream_bits.push_back(1'($urandom));
      nbytes = stream_bits.size() / 8;
      for (int i = 0; i < nbytes; i++) begin
         for (int j = 0; j < 8; j++)
            w.data_byte[7-j] = stream_bits[8*i+j];
         w.first_byte = (i == 0);
         w.last_byte  = with_last && (i == nbytes - 1);
         send_word(w);
      end
   endtask

   task automatic run_scan(input scan_kind_type kind);
      logic [63:0] gap;
      logic [63:0] d;
      int n;
      int cap;
      int keep;
      stream_bits.delete();
      if (kind == SCAN_NOISE) begin
         repeat (8 * $urandom_range(1, 8)) stream_bits.push_back(1'($urandom));
         send_stream($urandom_range(0, 3) != 0);
         return;
      end
      cap = (ph_rice > 6'd20) ? 3 : 10;
      n = (ph_size < 32'(cap)) ? int'(ph_size) : cap;
      if (n == 0)
         n = 1;
      if (kind != SCAN_COUNT)
         n = $urandom_range(1, n);
      // deltas steer the running sum onto, past or short of the mapped target
      gap = ph_target;
      for (int k = 0; k < n; k++) begin
         if (kind == SCAN_COUNT)
            d = pick_upto(gap / 64'(2 * n));
         else if (k == n - 1)
            d = (kind == SCAN_PASS) ? gap + 64'd1 + pick_upto(64'd3 << ph_rice) : gap;
         else
            d = pick_upto(gap / 64'(n - k));
         put_element(d);
         gap = gap - d;
      end
      if (kind == SCAN_TRUNC && stream_bits.size() > 1) begin
         keep = $urandom_range(1, stream_bits.size() - 1);
         while (stream_bits.size() > keep) void'(stream_bits.pop_back());
      end
      send_stream(kind == SCAN_TRUNC || $urandom_range(0, 7) != 0);
   endtask

   task automatic run_phase(input logic [5:0] rice, input logic [31:0] size_n,
                            input logic [31:0] rate, input int scans, input bit forced,
                            input scan_kind_type forced_kind);
      logic [63:0]   bound;
      logic [63:0]   hash;
      logic [127:0]  num;
      scan_kind_type kind;
      grsm_req_type  w;
      ph_rice   = rice;
      ph_size   = size_n;
      bound     = 64'(rate) * 64'(size_n);
      ph_target = (rice >= 6'd58) ? pick_upto('1) : pick_upto(64'd24 << rice);
      if (bound == '0) begin
         hash = {$urandom, $urandom};
      end else begin
         if (ph_target >= bound)
            ph_target = pick_upto(bound - 64'd1);
         // smallest hash whose scaled upper half lands on the target
         num  = {ph_target, 64'd0} + 128'(bound) - 128'd1;
         hash = 64'(num / 128'(bound));
      end
      write_regs(rice, size_n, rate, hash);
      for (int s = 0; s < scans; s++) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: kind = SCAN_MATCH;
            4, 5:       kind = SCAN_PASS;
            6, 7:       kind = SCAN_COUNT;
            8:          kind = SCAN_TRUNC;
            default:    kind = SCAN_NOISE;
         endcase
         if (forced)
            kind = forced_kind;
         if ($urandom_range(0, 5) == 0) begin
            w = {8'($urandom), 1'b0, 1'($urandom)};
            send_word(w);
         end
         run_scan(kind);
         if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 2)) begin
               w = {8'($urandom), 1'b0, 1'($urandom)};
               send_word(w);
            end
         end
         if ($urandom_range(0, 9) == 0)
            wait_for_results(0);
      end
      wait_for_results(DRAIN_TAIL);
   endtask

   initial begin
      logic [5:0]  rice;
      logic [31:0] size_n;
      logic [31:0] rate;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset registers: stray byte is ignored, empty set decides at once
      send_word({8'hFF, 1'b0, 1'b0});
      send_word({8'h00, 1'b1, 1'b0});
      send_word({8'hFF, 1'b1, 1'b1});
      send_word({8'h00, 1'b0, 1'b1});
      wait_for_results(DRAIN_TAIL);

      run_phase(6'd0, 32'd3, '1, 1, 1'b1, SCAN_MATCH);
      run_phase(6'd0, 32'd3, 32'd1, 1, 1'b1, SCAN_COUNT);
      run_phase(6'd63, '1, '1, 1, 1'b1, SCAN_PASS);
      run_phase(6'd63, 32'd1, 32'd1, 1, 1'b1, SCAN_TRUNC);

      // long receiver hold while short scans keep coming: both queues fill
      hold_request = 1'b1;
      run_phase(6'd1, 32'd2, $urandom, 16, 1'b1, SCAN_MATCH);

      while (words_sent < TOTAL_WORDS) begin
         case ($urandom_range(0, 9))
            0, 1, 2: rice = 6'($urandom_range(0, 3));
            3, 4, 5: rice = 6'($urandom_range(4, 12));
            6:       rice = 6'($urandom_range(13, 30));
            7:       rice = 6'($urandom_range(31, 62));
            8:       rice = 6'd63;
            default: rice = 6'($urandom_range(0, 63));
         endcase
         case ($urandom_range(0, 9))
            0:       size_n = '0;
            1:       size_n = '1;
            2:       size_n = 32'd1;
            3:       size_n = $urandom;
            default: size_n = 32'($urandom_range(2, 12));
         endcase
         case ($urandom_range(0, 9))
            0:       rate = 32'd1;
            1:       rate = '1;
            default: rate = $urandom_range(32'h0010_0000, 32'hFFFF_FFFF);
         endcase
         run_phase(rice, size_n, rate, $urandom_range(2, 10), 1'b0, SCAN_MATCH);
      end

      if (fail_count == 0 && pending_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/grsm_pkg.sv
rtl/grsm_front.sv
rtl/grsm_range.sv
rtl/grsm_back.sv
rtl/golomb_rice_set_membership_scan.sv
tb/scan_verdict_checker.sv
tb/testbench.sv
